// ===== rtl/divider_timer_with_reload_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DIVIDER_TIMER_WITH_RELOAD_CORE_ASSERT_SVH
`define DIVIDER_TIMER_WITH_RELOAD_CORE_ASSERT_SVH

// Same-cycle implication under reset.
`define DTWR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtwr assertion failed");

// Next-cycle implication under reset.
`define DTWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtwr assertion failed");

`endif

// ===== rtl/dtwr_pkg.sv =====
package dtwr_pkg;

    localparam int MAX_TICKS = 63;
    localparam int CNT_W     = $clog2(MAX_TICKS + 1);

    localparam logic [7:0] CTRL_PAD     = 8'hF8;
    localparam logic [7:0] TIMER_MAX    = 8'hFF;
    localparam logic [2:0] RELOAD_DELAY = 3'd4;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_READ  = 2'd1,
        FN_WRITE = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        AD_DIV  = 2'd0,
        AD_TIMA = 2'd1,
        AD_TMA  = 2'd2,
        AD_TAC  = 2'd3
    } t_addr;

    typedef struct packed {
        logic exec;   // op outside a burst, loads result
        logic start;  // burst accepted
        logic step;   // one clock of a burst
        logic last;   // final clock, loads result
    } t_cmd;

    // tick counter bit watched for each rate select
    function automatic logic [3:0] trig_bit(input logic [1:0] sel);
        logic [3:0] b;
        case (sel)
            2'd0:    b = 4'd9;
            2'd1:    b = 4'd3;
            2'd2:    b = 4'd5;
            default: b = 4'd7;
        endcase
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(input logic [5:0] c);
        logic [CNT_W-1:0] r;
        if (int'(c) > MAX_TICKS) begin
            r = CNT_W'(MAX_TICKS);
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

endpackage

// ===== rtl/dtwr_if.sv =====
interface dtwr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic [5:0] tick_count;
    logic       cpu_stopped;

    modport source (output valid, func, reg_addr, write_data, tick_count, cpu_stopped,
                    input ready);
    modport sink   (input valid, func, reg_addr, write_data, tick_count, cpu_stopped,
                    output ready);
    modport mon    (input valid, ready, func, reg_addr, write_data, tick_count, cpu_stopped);
endinterface

interface dtwr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timer_irq;

    modport source (output valid, read_data, timer_irq, input ready);
    modport sink   (input valid, read_data, timer_irq, output ready);
    modport mon    (input valid, ready, read_data, timer_irq);
endinterface

// ===== rtl/divider_timer_with_reload_core.sv =====
// Channel   Dir  Fields
// i_in      in   func, reg_addr, write_data, tick_count, cpu_stopped
// o_out     out  read_data, timer_irq
//
// Reads, writes, func 3, stopped or empty bursts: result registered the cycle after the beat.
// A tick burst runs tick_count ticks through the datapath step loop, one tick per
// cycle; the result is registered on the last of them.
// i_rst_n (synchronous) clears all timer state and empties the result register.
// A result waiting on o_out holds off the next input beat.
module divider_timer_with_reload_core
    import dtwr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    dtwr_in_if.sink    i_in,
    dtwr_out_if.source o_out
);

    t_cmd cmd;

    dtwr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_func        (t_func'(i_in.func)),
        .i_tick_count  (i_in.tick_count),
        .i_cpu_stopped (i_in.cpu_stopped),
        .i_out_ready   (o_out.ready),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (cmd)
    );

    dtwr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (t_func'(i_in.func)),
        .i_addr      (t_addr'(i_in.reg_addr)),
        .i_wdata     (i_in.write_data),
        .o_read_data (o_out.read_data),
        .o_timer_irq (o_out.timer_irq)
    );

endmodule

// ===== rtl/dtwr_ctrl.sv =====
module dtwr_ctrl
    import dtwr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_func      i_func,
    input  logic [5:0] i_tick_count,
    input  logic       i_cpu_stopped,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] burst_len;
    logic             accept;
    logic             burst;

    assign burst_len  = sat_count(i_tick_count);
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign burst      = (i_func == FN_TICK) && !i_cpu_stopped && (burst_len != '0);

    always_comb begin
        o_cmd.exec  = accept && !burst;
        o_cmd.start = accept && burst;
        o_cmd.step  = (r_state == ST_TICK);
        o_cmd.last  = (r_state == ST_TICK) && (r_left == CNT_W'(1));
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_TICK;
                    n_left  = burst_len;
                end
            end
            ST_TICK: begin
                n_left = r_left - CNT_W'(1);
                if (o_cmd.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.exec || o_cmd.last;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/dtwr_dp.sv =====
module dtwr_dp
    import dtwr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_func      i_func,
    input  t_addr      i_addr,
    input  logic [7:0] i_wdata,
    output logic [7:0] o_read_data,
    output logic       o_timer_irq
);

    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_timer, n_timer;
    logic [7:0]  r_modulo, n_modulo;
    logic        r_en, n_en;
    logic [1:0]  r_sel, n_sel;
    logic [2:0]  r_reload, n_reload;
    logic        r_irq_acc, n_irq_acc;
    logic [7:0]  r_rd, n_rd;
    logic        r_irq, n_irq;

    logic [3:0]  bit_idx;
    logic [15:0] tick_inc;
    logic [2:0]  cd_dec;
    logic [7:0]  timer_pre;
    logic        step_edge, step_ovf;
    logic [7:0]  step_timer;
    logic [2:0]  step_reload;
    logic        wr_edge, wr_ovf;
    logic [7:0]  wr_timer;
    logic [7:0]  rd_mux;

    assign bit_idx = trig_bit(r_sel);
    assign tick_inc = r_tick + 16'd1;

    // one clock of a burst: reload countdown first, then the tick edge
    always_comb begin
        cd_dec    = r_reload;
        timer_pre = r_timer;
        if (r_reload != 3'd0) begin
            cd_dec = r_reload - 3'd1;
            if (cd_dec == 3'd0) begin
                timer_pre = r_modulo;
            end
        end
        step_edge   = r_en && r_tick[bit_idx] && !tick_inc[bit_idx];
        step_ovf    = step_edge && (timer_pre == TIMER_MAX);
        step_timer  = timer_pre;
        step_reload = cd_dec;
        if (step_ovf) begin
            step_timer  = 8'd0;
            step_reload = RELOAD_DELAY;
        end else if (step_edge) begin
            step_timer = timer_pre + 8'd1;
        end
    end

    // divider write drops the whole counter to zero
    assign wr_edge  = r_en && r_tick[bit_idx];
    assign wr_ovf   = wr_edge && (r_timer == TIMER_MAX);
    assign wr_timer = wr_ovf ? 8'd0 : (wr_edge ? r_timer + 8'd1 : r_timer);

    always_comb begin
        case (i_addr)
            AD_DIV:  rd_mux = r_tick[15:8];
            AD_TIMA: rd_mux = r_timer;
            AD_TMA:  rd_mux = r_modulo;
            AD_TAC:  rd_mux = CTRL_PAD | {5'd0, r_en, r_sel};
            default: rd_mux = 8'd0;
        endcase
    end

    always_comb begin
        n_tick    = r_tick;
        n_timer   = r_timer;
        n_modulo  = r_modulo;
        n_en      = r_en;
        n_sel     = r_sel;
        n_reload  = r_reload;
        n_irq_acc = r_irq_acc;
        n_rd      = r_rd;
        n_irq     = r_irq;

        if (i_cmd.start) begin
            n_irq_acc = 1'b0;
        end
        if (i_cmd.step) begin
            n_tick    = tick_inc;
            n_timer   = step_timer;
            n_reload  = step_reload;
            n_irq_acc = r_irq_acc | step_ovf;
        end
        if (i_cmd.last) begin
            n_rd  = 8'd0;
            n_irq = r_irq_acc | step_ovf;
        end
        if (i_cmd.exec) begin
            n_rd  = 8'd0;
            n_irq = 1'b0;
            case (i_func)
                FN_READ: begin
                    n_rd = rd_mux;
                end
                FN_WRITE: begin
                    case (i_addr)
                        AD_DIV: begin
                            n_tick  = 16'd0;
                            n_timer = wr_timer;
                            n_irq   = wr_ovf;
                            if (wr_ovf) begin
                                n_reload = RELOAD_DELAY;
                            end
                        end
                        AD_TIMA: n_timer  = i_wdata;
                        AD_TMA:  n_modulo = i_wdata;
                        AD_TAC: begin
                            n_en  = i_wdata[2];
                            n_sel = i_wdata[1:0];
                        end
                        default: begin
                            n_tick = r_tick;
                        end
                    endcase
                end
                default: begin
                    n_rd = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= 16'd0;
            r_timer   <= 8'd0;
            r_modulo  <= 8'd0;
            r_en      <= 1'b0;
            r_sel     <= 2'd0;
            r_reload  <= 3'd0;
            r_irq_acc <= 1'b0;
        end else begin
            r_tick    <= n_tick;
            r_timer   <= n_timer;
            r_modulo  <= n_modulo;
            r_en      <= n_en;
            r_sel     <= n_sel;
            r_reload  <= n_reload;
            r_irq_acc <= n_irq_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_irq <= n_irq;
    end

    assign o_read_data = r_rd;
    assign o_timer_irq = r_irq;

endmodule

// ===== rtl/dtwr_chk.sv =====
`include "divider_timer_with_reload_core_assert.svh"

module dtwr_chk
    import dtwr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_func,
    input logic [1:0] i_in_reg_addr,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_timer_irq
);

    logic       in_beat;
    logic       out_stall;
    logic [8:0] out_word;
    logic       wr_beat;
    logic       wr_ok;
    logic       tac_beat;
    logic       tac_ok;

    assign in_beat   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_out_read_data, i_out_timer_irq};
    assign wr_beat   = in_beat && (i_in_func == FN_WRITE);
    assign wr_ok     = i_out_valid && (i_out_read_data == 8'd0);
    assign tac_beat  = in_beat && (i_in_func == FN_READ) && (i_in_reg_addr == AD_TAC);
    assign tac_ok    = i_out_valid && (i_out_read_data[7:3] == 5'h1F) && !i_out_timer_irq;

    `DTWR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))
    `DTWR_ASSERT_NOW(a_no_beat_on_stall, i_clk, i_rst_n, out_stall, !i_in_ready)
    `DTWR_ASSERT_NEXT(a_write_result, i_clk, i_rst_n, wr_beat, wr_ok)
    `DTWR_ASSERT_NEXT(a_ctrl_read, i_clk, i_rst_n, tac_beat, tac_ok)

endmodule

bind divider_timer_with_reload_core dtwr_chk u_dtwr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_func       (i_in.func),
    .i_in_reg_addr   (i_in.reg_addr),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_read_data (o_out.read_data),
    .i_out_timer_irq (o_out.timer_irq)
);

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dtwr_pkg::*;

    localparam int RANDOM_BEATS = 1500;
    localparam int TAIL_CYCLES  = 80;
    localparam int SQUEEZE_AT   = 200;
    localparam int SQUEEZE_LEN  = 300;

    typedef struct packed {
        t_func      func;
        t_addr      addr;
        logic [7:0] data;
        logic [5:0] ticks;
        logic       stopped;
        logic       known;
        logic [7:0] exp_rd;
        logic       exp_irq;
    } t_row;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    dtwr_in_if  in_ch();
    dtwr_out_if out_ch();

    divider_timer_with_reload_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // timer model state
    logic [15:0] div_count   = '0;
    logic [7:0]  tima        = '0;
    logic [7:0]  tma         = '0;
    logic        tac_en      = 1'b0;
    logic [1:0]  tac_sel     = '0;
    logic [2:0]  reload_wait = '0;

    t_result timer_results_due[$];
    int      errors       = 0;
    int      beats_sent   = 0;
    int      results_seen = 0;
    int      irqs_seen    = 0;

    task automatic flag_error(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(99);
        if (k < 55) return 0;
        else if (k < 90) return $urandom_range(3, 1);
        else return $urandom_range(40, 8);
    endfunction

    // falling edge of the selected divider tap bumps TIMA; returns overflow
    function automatic logic tap_fall(input logic [15:0] was, input logic [15:0] now);
        int   tap;
        logic ovf;
        ovf = 1'b0;
        case (tac_sel)
            2'd0:    tap = 9;
            2'd1:    tap = 3;
            2'd2:    tap = 5;
            default: tap = 7;
        endcase
        if (tac_en && was[tap] && !now[tap]) begin
            if (tima == TIMER_MAX) begin
                tima        = '0;
                reload_wait = RELOAD_DELAY;
                ovf         = 1'b1;
            end else begin
                tima = tima + 8'd1;
            end
        end
        return ovf;
    endfunction

    function automatic t_result predict_timer(input t_row b);
        t_result     r;
        int          n;
        logic [15:0] nxt;
        r = '0;
        case (b.func)
            FN_TICK: begin
                n = (int'(b.ticks) > MAX_TICKS) ? MAX_TICKS : int'(b.ticks);
                if (!b.stopped) begin
                    for (int i = 0; i < n; i++) begin
                        if (reload_wait != 3'd0) begin
                            reload_wait = reload_wait - 3'd1;
                            if (reload_wait == 3'd0) tima = tma;
                        end
                        nxt = div_count + 16'd1;
                        if (tap_fall(div_count, nxt)) r.irq = 1'b1;
                        div_count = nxt;
                    end
                end
            end
            FN_READ: begin
                case (b.addr)
                    AD_DIV:  r.rd = div_count[15:8];
                    AD_TIMA: r.rd = tima;
                    AD_TMA:  r.rd = tma;
                    default: r.rd = CTRL_PAD | {5'd0, tac_en, tac_sel};
                endcase
            end
            FN_WRITE: begin
                case (b.addr)
                    AD_DIV: begin
                        if (tap_fall(div_count, 16'd0)) r.irq = 1'b1;
                        div_count = '0;
                    end
                    AD_TIMA: tima = b.data;
                    AD_TMA:  tma  = b.data;
                    default: begin
                        tac_en  = b.data[2];
                        tac_sel = b.data[1:0];
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_row step_row(input t_func f, input t_addr a, input logic [7:0] d,
                                      input logic [5:0] t, input logic s, input logic k,
                                      input logic [7:0] rd, input logic irq);
        t_row b;
        b.func    = f;
        b.addr    = a;
        b.data    = d;
        b.ticks   = t;
        b.stopped = s;
        b.known   = k;
        b.exp_rd  = rd;
        b.exp_irq = irq;
        return b;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("divider_timer_with_reload_core test failed");
        $finish;
    end

    initial begin : feed_beats
        t_row    script[$];
        t_row    b;
        t_result r;
        int      gap;
        int      total;
        logic    took;

        in_ch.valid       <= 1'b0;
        in_ch.func        <= FN_NOP;
        in_ch.reg_addr    <= AD_DIV;
        in_ch.write_data  <= '0;
        in_ch.tick_count  <= '0;
        in_ch.cpu_stopped <= 1'b0;

        //                       func      addr     data   tick  stop known rd     irq
        script.push_back(step_row(FN_READ,  AD_DIV,  8'h00, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TIMA, 8'h00, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TMA,  8'h00, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TAC,  8'h00, 6'd0,  0, 1, 8'hF8, 0));
        script.push_back(step_row(FN_NOP,   AD_TAC,  8'hFF, 6'd63, 1, 1, 8'h00, 0));
        script.push_back(step_row(FN_WRITE, AD_TMA,  8'hFF, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TMA,  8'h00, 6'd0,  0, 1, 8'hFF, 0));
        script.push_back(step_row(FN_WRITE, AD_TAC,  8'h05, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TAC,  8'h00, 6'd0,  0, 1, 8'hFD, 0));
        script.push_back(step_row(FN_WRITE, AD_TIMA, 8'hFF, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd16, 0, 0, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd63, 1, 1, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd2,  0, 0, 8'h00, 0));
        // TIMA write lands while the reload is still pending
        script.push_back(step_row(FN_WRITE, AD_TIMA, 8'h10, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd3,  0, 0, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TIMA, 8'h00, 6'd0,  0, 0, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd8,  0, 0, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd4,  0, 0, 8'h00, 0));
        // DIV clear with the tap bit low does not count as an edge
        script.push_back(step_row(FN_WRITE, AD_DIV,  8'hFF, 6'd0,  0, 0, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_DIV,  8'h00, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_WRITE, AD_TAC,  8'h06, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_TICK,  AD_DIV,  8'h00, 6'd63, 0, 0, 8'h00, 0));
        script.push_back(step_row(FN_WRITE, AD_TAC,  8'h03, 6'd0,  0, 1, 8'h00, 0));
        script.push_back(step_row(FN_READ,  AD_TIMA, 8'h00, 6'd0,  0, 0, 8'h00, 0));

        wait (i_rst_n);
        @(posedge i_clk);

        total = script.size() + RANDOM_BEATS;
        for (int n = 0; n < total; n++) begin
            if (n < script.size()) begin
                b = script[n];
            end else begin
                b       = '0;
                b.data  = 8'($urandom);
                b.ticks = 6'($urandom);
                b.addr  = t_addr'($urandom_range(3));
                gap     = $urandom_range(99);
                if (gap < 45) begin
                    b.func = FN_TICK;
                    if ($urandom_range(1) == 0) b.ticks = 6'($urandom_range(6));
                    b.stopped = ($urandom_range(9) == 0);
                end else if (gap < 70) begin
                    b.func = FN_READ;
                end else if (gap < 95) begin
                    b.func = FN_WRITE;
                    if (b.addr == AD_TIMA && $urandom_range(1) == 0)
                        b.data = 8'($urandom_range(8'hFF, 8'hF8));
                    if (b.addr == AD_TAC)
                        b.data[2] = ($urandom_range(4) != 0);
                end else begin
                    b.func    = FN_NOP;
                    b.stopped = 1'($urandom);
                end
            end

            gap = ((n / 100) % 4 == 3) ? 0 : pick_gap();
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid       <= 1'b1;
            in_ch.func        <= b.func;
            in_ch.reg_addr    <= b.addr;
            in_ch.write_data  <= b.data;
            in_ch.tick_count  <= b.ticks;
            in_ch.cpu_stopped <= b.stopped;
            // ready is settled mid-cycle, so sample it there for the coming edge
            took = 1'b0;
            while (!took) begin
                @(negedge i_clk);
                took = in_ch.ready;
                @(posedge i_clk);
            end

            r = predict_timer(b);
            if (b.known) begin
                r.rd  = b.exp_rd;
                r.irq = b.exp_irq;
            end
            timer_results_due.push_back(r);
            beats_sent++;
        end
        in_ch.valid <= 1'b0;

        while (timer_results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats (%0d scripted) across ticks, reads, writes and no-ops;",
                 beats_sent, script.size());
        $display("checked %0d results, %0d carrying a timer interrupt.",
                 results_seen, irqs_seen);
        if (errors == 0) begin
            $display("divider_timer_with_reload_core test passed");
        end else begin
            $display("divider_timer_with_reload_core test failed");
        end
        $finish;
    end

    initial begin : drain_results
        t_result    want;
        int         stall;
        int         hold;
        logic       squeezed;
        logic       took;
        logic [7:0] got_rd;
        logic       got_irq;

        stall    = 0;
        squeezed = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n);

        forever begin
            @(negedge i_clk);
            took    = out_ch.valid && out_ch.ready;
            got_rd  = out_ch.read_data;
            got_irq = out_ch.timer_irq;
            @(posedge i_clk);
            if (took) begin
                results_seen++;
                if (got_irq === 1'b1) irqs_seen++;
                if (timer_results_due.size() == 0) begin
                    flag_error("result beat with nothing outstanding");
                end else begin
                    want = timer_results_due.pop_front();
                    if (got_rd !== want.rd)
                        flag_error($sformatf("read_data %h, want %h", got_rd, want.rd));
                    if (got_irq !== want.irq)
                        flag_error($sformatf("timer_irq %b, want %b", got_irq, want.irq));
                end
            end

            // one long hold-off so the core backs up onto its input
            if (!squeezed && results_seen == SQUEEZE_AT) begin
                squeezed = 1'b1;
                out_ch.ready <= 1'b0;
                hold = SQUEEZE_LEN;
                while (hold > 0) begin
                    @(posedge i_clk);
                    hold--;
                end
            end

            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(3) == 0) stall = pick_gap();
            end
        end
    end

endmodule

// ===== divider_timer_with_reload_core.f =====
+incdir+rtl
rtl/dtwr_pkg.sv
rtl/dtwr_if.sv
rtl/dtwr_ctrl.sv
rtl/dtwr_dp.sv
rtl/divider_timer_with_reload_core.sv
rtl/dtwr_chk.sv
tb/sv/testbench.sv
